FILE: rtl/fgn_pkg.sv
// ----------------------------------------------------------------------------
// fgn_pkg
// Types and constants shared by the fractal gradient noise block.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned FracW  = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OP_LOAD_PERM = 2'd0,
    OP_LOAD_GRAD = 2'd1,
    OP_EVAL      = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SCALE    = 3'd0,
    REG_OFFSET_X = 3'd1,
    REG_OFFSET_Y = 3'd2,
    REG_OCTAVES  = 3'd3,
    REG_PERSIST  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         table_index;
    logic [7:0]         perm_entry;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
  } noise_req_t;

  typedef struct packed {
    logic signed [31:0] noise_value;
    logic signed [31:0] min_seen;
    logic signed [31:0] max_seen;
  } noise_rsp_t;

  // Sequencer states; one pass of the shared multiplier per multiply step.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CX,      // cx = px*scale+off
    S_CY,
    S_P0,      // read perm[bx0]
    S_P1,      // read perm[bx1]
    S_H0,      // read perm[i+by0]
    S_H1,
    S_H2,
    S_H3,
    S_SF,      // f*f
    S_SK,      // f2*k
    S_G,       // corner products, 8 of them over one counter
    S_LERP,    // three lerps
    S_AMP,     // octave*amp
    S_PERS,    // amp*persistence
    S_DONE,
    S_OUT
  } state_t;

  localparam logic signed [31:0] MaxS32 = 32'sh7fffffff;
  localparam logic signed [31:0] MinS32 = 32'sh80000000;

endpackage

FILE: rtl/fgn_stream_if.sv
// ----------------------------------------------------------------------------
// fgn_stream_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface fgn_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/fractal_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d
// 2D gradient noise summed over octaves, one shared multiplier.
// ----------------------------------------------------------------------------
// Each transaction returns one result. A table load or a min/max clear passes
// from idle through the done and output states before the next transaction is
// taken. An evaluate first forms the coordinates, then per octave (octaves
// counted after the MAX_OCTAVES clamp) the sequencer does six single-port
// permutation reads, two squares and two cubic smoothstep terms, eight corner
// products, three lerps and the two amplitude steps on one registered
// multiplier. The block takes no item while busy, and a waiting result holds
// it until the result is taken.
module fractal_gradient_noise_2d
  import fgn_pkg::*;
#(
  parameter int unsigned MAX_COORD   = 4096,
  parameter int unsigned MAX_OCTAVES = 16
) (
  input  logic clk,
  input  logic rst,
  fgn_stream_if.sink   in_ch,
  fgn_stream_if.source out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgW-1:0]     cfg_data
);
  localparam int unsigned PW = 12;
  localparam logic [16:0] PxMax = 17'(MAX_COORD - 1);
  localparam logic [5:0] OctMax = 6'(MAX_OCTAVES);

  logic [CoordW-1:0] coord_scale, offset_x, offset_y;
  logic [4:0] octave_count;
  logic signed [15:0] persistence;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_scale  <= 24'd65536;
      offset_x     <= '0;
      offset_y     <= '0;
      octave_count <= 5'd1;
      persistence  <= 16'sd8192;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCALE:    coord_scale  <= cfg_data;
        REG_OFFSET_X: offset_x     <= cfg_data;
        REG_OFFSET_Y: offset_y     <= cfg_data;
        REG_OCTAVES:  octave_count <= cfg_data[4:0];
        REG_PERSIST:  persistence  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // tables
  logic [7:0]  perm_mem [256];
  logic [31:0] grad_mem [256];
  logic [7:0]  perm_addr, grad_addr, perm_q;
  logic [31:0] grad_q;
  logic        in_fire;
  op_t         op_in;

  assign op_in   = op_t'(in_ch.data.op);
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire && op_in == OP_LOAD_PERM)
      perm_mem[in_ch.data.table_index] <= in_ch.data.perm_entry;
    if (in_fire && op_in == OP_LOAD_GRAD)
      grad_mem[in_ch.data.table_index] <= {in_ch.data.grad_y, in_ch.data.grad_x};
    perm_q <= perm_mem[perm_addr];
    grad_q <= grad_mem[grad_addr];
  end

  // datapath registers
  state_t state, state_next;
  logic [PW-1:0] px, py;
  logic [CoordW-1:0] cx, cy;
  logic [7:0] pi, pj;
  logic [7:0] h [4];
  logic [2:0] cnt;
  logic [1:0] sub;
  logic [5:0] oct_left;
  logic signed [32:0] f2, sx, sy;
  logic signed [47:0] dot;
  logic signed [32:0] cv [4];
  logic signed [32:0] la, lb, oval;
  logic signed [15:0] amp;
  logic signed [47:0] sum;
  logic signed [31:0] min_value, max_value, noise;
  logic out_valid;
  logic pers_d;
  logic evaluating;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  fgn_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  logic [7:0] bx0, by0;
  logic signed [32:0] rx0, ry0, rx1, ry1;
  assign bx0 = cx[23:16];
  assign by0 = cy[23:16];
  assign rx0 = {17'd0, cx[15:0]};
  assign ry0 = {17'd0, cy[15:0]};
  assign rx1 = rx0 - 33'sd65536;
  assign ry1 = ry0 - 33'sd65536;

  // corner c (0..3): x side c[0], y side c[1]; cnt[0] 0 x product, 1 y product
  logic [1:0] cc;
  assign cc = cnt[2:1];
  logic signed [32:0] lerp_a, lerp_b, lerp_s;

  always_comb begin
    state_next = state;
    ma = '0;
    mb = '0;
    perm_addr = bx0;
    grad_addr = h[cc];
    lerp_a = la; lerp_b = lb; lerp_s = sy;
    case (cnt[1:0])
      2'd0: begin lerp_a = cv[0]; lerp_b = cv[1]; lerp_s = sx; end
      2'd1: begin lerp_a = cv[2]; lerp_b = cv[3]; lerp_s = sx; end
      default: ;
    endcase
    case (state)
      S_IDLE: if (in_fire) state_next = (op_in == OP_EVAL) ? S_CX : S_DONE;
      S_CX: begin
        ma = {21'd0, px}; mb = {9'd0, coord_scale}; state_next = S_CY;
      end
      S_CY: begin
        ma = {21'd0, py}; mb = {9'd0, coord_scale};
        state_next = (oct_left == 0) ? S_DONE : S_P0;
      end
      S_P0: begin perm_addr = bx0; state_next = S_P1; end
      S_P1: begin perm_addr = bx0 + 8'd1; state_next = S_H0; end
      S_H0: begin perm_addr = pi + by0; state_next = S_H1; end
      S_H1: begin perm_addr = pj + by0; state_next = S_H2; end
      S_H2: begin perm_addr = pi + by0 + 8'd1; state_next = S_H3; end
      S_H3: begin perm_addr = pj + by0 + 8'd1; state_next = S_SF; end
      S_SF: begin
        // cnt 0: fx*fx, 1: fy*fy
        ma = cnt[0] ? ry0 : rx0; mb = ma;
        if (cnt[0]) state_next = S_SK;
      end
      S_SK: begin
        ma = f2; mb = 33'sd196608 - 2 * (cnt[0] ? ry0 : rx0);
        if (cnt[0]) state_next = S_G;
      end
      S_G: begin
        grad_addr = h[cc];
        if (sub == 2'd2) begin
          ma = cnt[0] ? (cc[1] ? ry1 : ry0) : (cc[0] ? rx1 : rx0);
          mb = cnt[0] ? {{17{grad_q[31]}}, grad_q[31:16]}
                      : {{17{grad_q[15]}}, grad_q[15:0]};
        end
        if (sub == 2'd3 && cnt == 3'd7) state_next = S_LERP;
      end
      S_LERP: begin
        ma = lerp_s; mb = lerp_b - lerp_a;
        if (sub == 2'd1 && cnt[1:0] == 2'd2) state_next = S_AMP;
      end
      S_AMP: begin
        ma = oval; mb = {{17{amp[15]}}, amp}; state_next = S_PERS;
      end
      S_PERS: begin
        ma = {{17{amp[15]}}, amp}; mb = {{17{persistence[15]}}, persistence};
        state_next = (oct_left == 6'd1) ? S_DONE : S_P0;
      end
      S_DONE: state_next = S_OUT;
      S_OUT: if (!out_valid) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic signed [65:0] dot_sum;
  logic signed [65:0] amp_full;
  logic signed [47:0] sum_add;
  logic signed [31:0] sat_sum;
  assign dot_sum = {{18{dot[47]}}, dot} + mp;
  assign amp_full = mp >>> 14;
  assign sum_add = sum + 48'(mp >>> 14);

  always_comb begin
    if (sum > 48'(MaxS32)) sat_sum = MaxS32;
    else if (sum < 48'(MinS32)) sat_sum = MinS32;
    else sat_sum = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      min_value <= MaxS32;
      max_value <= MinS32;
      cnt <= '0;
      sub <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_fire) begin
          px <= ({5'd0, in_ch.data.pixel_x} > PxMax) ? PxMax[PW-1:0]
                                                      : in_ch.data.pixel_x;
          py <= ({5'd0, in_ch.data.pixel_y} > PxMax) ? PxMax[PW-1:0]
                                                      : in_ch.data.pixel_y;
          oct_left <= (6'(octave_count) > OctMax) ? OctMax : 6'(octave_count);
          amp <= 16'sd16384;
          sum <= '0;
          noise <= '0;
          if (op_in == OP_CLEAR) begin
            min_value <= MaxS32;
            max_value <= MinS32;
          end
          cnt <= '0;
          sub <= '0;
        end
        S_CY: cx <= mp[23:0] + offset_x;
        // first octave only: land the y coordinate
        S_P0: if (!pers_d) cy <= mp[23:0] + offset_y;
        S_P1: pi <= perm_q;
        S_H0: pj <= perm_q;
        S_H1: h[0] <= perm_q;
        S_H2: h[1] <= perm_q;
        S_H3: h[2] <= perm_q;
        S_SF: begin
          if (cnt[0]) f2 <= 33'(mp >>> 16);
          cnt <= cnt[0] ? 3'd0 : 3'd1;
          if (cnt == 3'd0) h[3] <= perm_q;
        end
        S_SK: begin
          if (cnt == 3'd0) f2 <= 33'(mp >>> 16);
          if (cnt == 3'd1) sx <= 33'(mp >>> 16);
          cnt <= cnt[0] ? 3'd0 : 3'd1;
          sub <= '0;
          dot <= '0;
        end
        S_G: begin
          if (sub == 2'd2) begin
            sub <= 2'd3;
          end else if (sub == 2'd3) begin
            if (cnt[0]) begin
              cv[cc] <= 33'(dot_sum >>> 15);
              dot <= '0;
            end else dot <= dot_sum[47:0];
            cnt <= cnt + 3'd1;
            sub <= 2'd0;
            if (cnt == 3'd7) begin cnt <= '0; sub <= '0; end
          end else sub <= sub + 2'd1;
          if (cnt == 3'd0 && sub == 2'd0) sy <= 33'(mp >>> 16);
        end
        S_LERP: begin
          if (sub == 2'd0) sub <= 2'd1;
          else begin
            sub <= 2'd0;
            cnt <= cnt + 3'd1;
            case (cnt[1:0])
              2'd0: la <= lerp_a + 33'(mp >>> 16);
              2'd1: lb <= lerp_a + 33'(mp >>> 16);
              default: oval <= lerp_a + 33'(mp >>> 16);
            endcase
          end
        end
        S_AMP: begin
          cnt <= '0;
        end
        S_PERS: begin
          sum <= sum_add;
          cx <= {cx[22:0], 1'b0};
          cy <= {cy[22:0], 1'b0};
          oct_left <= oct_left - 6'd1;
        end
        default: ;
      endcase
      // amplitude update lands in the cycle after S_PERS issues
      if (pers_d) begin
        if (amp_full > 66'sd32767) amp <= 16'sd32767;
        else if (amp_full < -66'sd32768) amp <= -16'sd32768;
        else amp <= amp_full[15:0];
      end
      if (state == S_DONE && evaluating) begin
        noise <= sat_sum;
        if (sat_sum < min_value) min_value <= sat_sum;
        if (sat_sum > max_value) max_value <= sat_sum;
      end
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pers_d <= 1'b0;
      evaluating <= 1'b0;
    end else begin
      pers_d <= (state == S_PERS);
      if (state == S_IDLE && in_fire) evaluating <= (op_in == OP_EVAL);
    end
  end

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data.noise_value = noise;
  assign out_ch.data.min_seen    = min_value;
  assign out_ch.data.max_seen    = max_value;
endmodule

FILE: rtl/fgn_mul.sv
// ----------------------------------------------------------------------------
// fgn_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module fgn_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

FILE: rtl/fgn_checker.sv
// ----------------------------------------------------------------------------
// fgn_checker
// Port-level checks of the noise block handshakes.
// ----------------------------------------------------------------------------
module fgn_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second transaction taken");
endmodule

bind fractal_gradient_noise_2d fgn_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready));
